[rtl/pcpc_pkg.sv]
// ----------------------------------------------------------------------------
// pcpc_pkg
// Shared field widths, codes, constants and the constant table of the pen cone check.
// ----------------------------------------------------------------------------
package pcpc_pkg;

  // Field and fixed-point widths.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 15;

  // Timing constants in milliseconds.
  localparam logic [31:0] ACTIVE_MS    = 32'd300;
  localparam logic [33:0] HALF_LIFE_MS = 34'd1000;

  // Item kinds.
  localparam logic [1:0] KIND_POS    = 2'd0;
  localparam logic [1:0] KIND_DIR    = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_COS    = 1'b1;

  // Weight 1.0 in Q30.
  localparam logic [30:0] W_ONE = 31'h4000_0000;

  // Builds c_k = 2^(-2^-k) in Q30 for k = 1..FRAC_BITS by repeated square roots.
  function automatic logic [FRAC_BITS*30-1:0] build_ctab();
    logic [FRAC_BITS*30-1:0] tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    tab = '0;
    c   = 64'd1 << 29;
    for (int k = 0; k < FRAC_BITS; k++) begin
      v = c << 30;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
      tab[k*30 +: 30] = c[29:0];
    end
    return tab;
  endfunction

  localparam logic [FRAC_BITS*30-1:0] C_TAB = build_ctab();

endpackage

[rtl/pcpc_ifs.sv]
// ----------------------------------------------------------------------------
// pcpc channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pcpc_item_if;
  import pcpc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;
  logic [31:0]                  now_ms;

  modport source (output valid, kind, x, y, now_ms, input ready);
  modport sink   (input valid, kind, x, y, now_ms, output ready);
endinterface

interface pcpc_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic alive;
  logic active;

  modport source (output valid, inside_res, alive, active, input ready);
  modport sink   (input valid, inside_res, alive, active, output ready);
endinterface

[rtl/pen_cone_palm_check.sv]
// ----------------------------------------------------------------------------
// pen_cone_palm_check
// Pen cone tracker for palm rejection: apex, decaying direction and cone test.
// ----------------------------------------------------------------------------
//
//  Channel      Dir  Beat contents
//  item_in      in   kind, x, y, now_ms
//  result_out   out  inside_res, alive, active
//  cfg_*        in   cfg_index, cfg_data (write only, no handshake)
//
//  One item is worked at a time; item_in.ready is high only while idle.
//  Position and unused kinds go straight to the finish state; checks and
//  direction updates run on the shared shift-subtract unit (one quotient
//  or root bit per cycle) and the single shared multiplier.
//  A finished result waits in the output register while a new item is taken;
//  a stalled result_out holds the next result until the register frees.
//  Reset (rst, synchronous) clears all tracker state and both registers.
//
module pen_cone_palm_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  pcpc_item_if.sink            item_in,
  pcpc_result_if.source        result_out
);
  import pcpc_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_DIVQ  = 22'h000002,
    S_DIVF  = 22'h000004,
    S_WMUL  = 22'h000008,
    S_WFIN  = 22'h000010,
    S_NSQA  = 22'h000020,
    S_NSQB  = 22'h000040,
    S_NSUM  = 22'h000080,
    S_NBR   = 22'h000100,
    S_NDIV  = 22'h000200,
    S_NSQRT = 22'h000400,
    S_NCOMP = 22'h000800,
    S_NEND  = 22'h001000,
    S_SX    = 22'h002000,
    S_SY    = 22'h004000,
    S_CRAD  = 22'h008000,
    S_CSQRT = 22'h010000,
    S_CDX   = 22'h020000,
    S_CDY   = 22'h040000,
    S_CCD   = 22'h080000,
    S_CCMP  = 22'h100000,
    S_DONE  = 22'h200000
  } state_t;

  localparam logic signed [16:0] DIR_ONE = 17'sd32768;

  state_t state;

  // Configuration registers.
  logic [15:0]        cone_radius;
  logic signed [15:0] cone_cos_angle;

  // Tracker state.
  logic signed [15:0] apex_x;
  logic signed [15:0] apex_y;
  logic [31:0]        position_time;
  logic               position_seen;
  logic signed [16:0] dir_x;
  logic signed [16:0] dir_y;
  logic [31:0]        direction_time;
  logic               direction_seen;

  // Item and working registers.
  logic [1:0]         kind;
  logic [31:0]        now;
  logic signed [18:0] va;
  logic signed [18:0] vb;
  logic [32:0]        sq_a;
  logic [32:0]        sq_b;
  logic [33:0]        ssum;
  logic [31:0]        rad_sq;
  logic signed [16:0] ua;
  logic signed [16:0] ub;
  logic               comp_b;
  logic               pass;
  logic [30:0]        w;
  logic [14:0]        f;
  logic [3:0]         kc;
  logic               qsat;
  logic [4:0]         qsh;
  logic [15:0]        wt;
  logic signed [34:0] dot_a;
  logic signed [34:0] dot_b;
  logic signed [34:0] cd;
  logic               hit;

  // Shift-subtract unit registers.
  logic [34:0] rem;
  logic [33:0] quo;
  logic [33:0] den;
  logic [33:0] feed;
  logic        nshift;
  logic [4:0]  cnt;

  // Output register.
  logic res_valid;
  logic res_inside;
  logic res_alive;
  logic res_active;

  logic in_acc;
  logic out_free;
  logic active_in;
  logic active_now;

  assign in_acc     = item_in.valid && item_in.ready;
  assign out_free   = !res_valid || result_out.ready;
  assign active_in  = position_seen && ((item_in.now_ms - position_time) < ACTIVE_MS);
  assign active_now = position_seen && ((now - position_time) < ACTIVE_MS);

  assign item_in.ready         = (state == S_IDLE);
  assign result_out.valid      = res_valid;
  assign result_out.inside_res = res_inside;
  assign result_out.alive      = res_alive;
  assign result_out.active     = res_active;

  // Shared step: one restoring division bit or one square-root bit per cycle.
  logic        sq_mode;
  logic [35:0] t_val;
  logic [35:0] sub_val;
  logic [36:0] diff;
  logic        ge;
  logic [34:0] rem_step;
  logic [33:0] quo_step;
  logic [33:0] feed_step;

  always_comb begin
    sq_mode = (state == S_NSQRT) || (state == S_CSQRT);
    if (sq_mode) begin
      t_val   = {rem[33:0], feed[33:32]};
      sub_val = {17'd0, quo[16:0], 2'b01};
    end else begin
      t_val   = nshift ? {1'b0, rem} : {rem, feed[33]};
      sub_val = {2'b00, den};
    end
    diff      = {1'b0, t_val} - {1'b0, sub_val};
    ge        = ~diff[36];
    rem_step  = ge ? diff[34:0] : t_val[34:0];
    quo_step  = {quo[32:0], ge};
    feed_step = sq_mode ? {feed[31:0], 2'b00} : {feed[32:0], 1'b0};
  end

  // Shared multiplier, operands chosen by state.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  always_comb begin
    case (state)
      S_NSQA: begin
        mul_a = {{13{va[18]}}, va};
        mul_b = {{13{va[18]}}, va};
      end
      S_NSQB: begin
        mul_a = {{13{vb[18]}}, vb};
        mul_b = {{13{vb[18]}}, vb};
      end
      S_NSUM: begin
        mul_a = {16'd0, cone_radius};
        mul_b = {16'd0, cone_radius};
      end
      S_WMUL: begin
        mul_a = {1'b0, w};
        mul_b = {2'b00, C_TAB[kc*30 +: 30]};
      end
      S_SX: begin
        mul_a = {16'd0, wt};
        mul_b = {{15{dir_x[16]}}, dir_x};
      end
      S_SY: begin
        mul_a = {16'd0, wt};
        mul_b = {{15{dir_y[16]}}, dir_y};
      end
      S_CDX: begin
        mul_a = {{13{va[18]}}, va};
        mul_b = {{15{dir_x[16]}}, dir_x};
      end
      S_CDY: begin
        mul_a = {{13{vb[18]}}, vb};
        mul_b = {{15{dir_y[16]}}, dir_y};
      end
      S_CCD: begin
        mul_a = {{16{cone_cos_angle[15]}}, cone_cos_angle};
        mul_b = {15'd0, quo[16:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Signed unit component from the root just found.
  logic [30:0]        w_shr;
  logic               comp_neg;
  logic signed [16:0] comp_val;
  logic signed [35:0] dot_sum;

  always_comb begin
    w_shr    = w >> qsh;
    comp_neg = comp_b ? vb[18] : va[18];
    comp_val = comp_neg ? (17'sd0 - $signed({1'b0, quo[15:0]})) : $signed({1'b0, quo[15:0]});
    dot_sum  = {dot_a[34], dot_a} + {dot_b[34], dot_b};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cone_radius    <= '0;
      cone_cos_angle <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: cone_radius    <= cfg_data;
        CFG_COS:    cone_cos_angle <= $signed(cfg_data);
        default:    ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      res_inside <= hit;
      res_alive  <= position_seen;
      res_active <= active_now;
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      apex_x         <= '0;
      apex_y         <= '0;
      position_time  <= '0;
      position_seen  <= 1'b0;
      dir_x          <= '0;
      dir_y          <= '0;
      direction_time <= '0;
      direction_seen <= 1'b0;
    end else begin
      // The shift-subtract unit advances one bit in each of its run states;
      // the last division cycles reload the unit in their own arms.
      if (((state == S_DIVQ || state == S_NDIV) && cnt != 5'd0) ||
          state == S_DIVF || state == S_NSQRT || state == S_CSQRT) begin
        rem    <= rem_step;
        quo    <= quo_step;
        feed   <= feed_step;
        nshift <= 1'b0;
        cnt    <= cnt - 5'd1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            kind   <= item_in.kind;
            now    <= item_in.now_ms;
            hit    <= 1'b0;
            pass   <= 1'b0;
            va     <= {{3{item_in.x[15]}}, item_in.x} - {{3{apex_x[15]}}, apex_x};
            vb     <= {{3{item_in.y[15]}}, item_in.y} - {{3{apex_y[15]}}, apex_y};
            case (item_in.kind)
              KIND_POS: begin
                apex_x        <= item_in.x;
                apex_y        <= item_in.y;
                position_time <= item_in.now_ms;
                position_seen <= 1'b1;
                state         <= S_DONE;
              end
              KIND_DIR: begin
                if (direction_seen) begin
                  rem    <= '0;
                  quo    <= '0;
                  den    <= HALF_LIFE_MS;
                  feed   <= {item_in.now_ms - direction_time, 2'b00};
                  nshift <= 1'b0;
                  cnt    <= 5'd31;
                  state  <= S_DIVQ;
                end else begin
                  wt    <= '0;
                  state <= S_NSQA;
                end
              end
              KIND_CHECK: begin
                state <= active_in ? S_NSQA : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // Whole half-lives, then the fraction of a half-life in Q15.
        S_DIVQ: begin
          if (cnt == 5'd0) begin
            rem    <= rem_step;
            qsat   <= (|quo_step[31:5]) || (quo_step[4:0] == 5'd31);
            qsh    <= quo_step[4:0];
            quo    <= '0;
            feed   <= '0;
            nshift <= 1'b1;
            cnt    <= 5'(FRAC_BITS);
            state  <= S_DIVF;
          end
        end

        S_DIVF: begin
          if (cnt == 5'd0) begin
            f     <= quo_step[14:0];
            w     <= W_ONE;
            kc    <= '0;
            state <= S_WMUL;
          end
        end

        // Product of the root constants picked by the fraction bits.
        S_WMUL: begin
          if (f[14]) begin
            w <= mul_p[60:30];
          end
          f  <= {f[13:0], 1'b0};
          kc <= kc + 4'd1;
          if (kc == 4'(FRAC_BITS - 1)) begin
            state <= S_WFIN;
          end
        end

        S_WFIN: begin
          wt    <= qsat ? 16'd0 : w_shr[30:15];
          state <= S_NSQA;
        end

        // Squares of the vector held in va, vb.
        S_NSQA: begin
          sq_a  <= mul_p[32:0];
          state <= S_NSQB;
        end

        S_NSQB: begin
          sq_b  <= mul_p[32:0];
          state <= S_NSUM;
        end

        S_NSUM: begin
          ssum   <= {1'b0, sq_a} + {1'b0, sq_b};
          rad_sq <= mul_p[31:0];
          state  <= (kind == KIND_CHECK) ? S_CRAD : S_NBR;
        end

        // Zero length gives a zero vector; else start on the x component.
        S_NBR: begin
          if (ssum == 34'd0) begin
            ua    <= '0;
            ub    <= '0;
            state <= S_NEND;
          end else begin
            rem    <= {2'b00, sq_a};
            den    <= ssum;
            quo    <= '0;
            feed   <= '0;
            nshift <= 1'b1;
            cnt    <= 5'd30;
            comp_b <= 1'b0;
            state  <= S_NDIV;
          end
        end

        S_NDIV: begin
          if (cnt == 5'd0) begin
            rem   <= '0;
            quo   <= '0;
            feed  <= {3'b000, quo_step[30:0]};
            cnt   <= 5'd16;
            state <= S_NSQRT;
          end
        end

        S_NSQRT: begin
          if (cnt == 5'd0) begin
            state <= S_NCOMP;
          end
        end

        S_NCOMP: begin
          if (!comp_b) begin
            ua     <= comp_val;
            rem    <= {2'b00, sq_b};
            quo    <= '0;
            feed   <= '0;
            nshift <= 1'b1;
            cnt    <= 5'd30;
            comp_b <= 1'b1;
            state  <= S_NDIV;
          end else begin
            ub    <= comp_val;
            state <= S_NEND;
          end
        end

        // First pass gave the new unit vector; second pass the new direction.
        S_NEND: begin
          if (!pass) begin
            state <= S_SX;
          end else begin
            dir_x          <= ua;
            dir_y          <= ub;
            direction_time <= now;
            direction_seen <= 1'b1;
            state          <= S_DONE;
          end
        end

        S_SX: begin
          va    <= mul_p[33:15] + {{2{ua[16]}}, ua};
          state <= S_SY;
        end

        S_SY: begin
          vb    <= mul_p[33:15] + {{2{ub[16]}}, ub};
          pass  <= 1'b1;
          state <= S_NSQA;
        end

        // Check: radius test, then distance root and cone test.
        S_CRAD: begin
          if (ssum > {2'b00, rad_sq}) begin
            state <= S_DONE;
          end else begin
            rem   <= '0;
            quo   <= '0;
            feed  <= ssum;
            cnt   <= 5'd16;
            state <= S_CSQRT;
          end
        end

        S_CSQRT: begin
          if (cnt == 5'd0) begin
            state <= S_CDX;
          end
        end

        S_CDX: begin
          dot_a <= mul_p[34:0];
          state <= S_CDY;
        end

        S_CDY: begin
          dot_b <= mul_p[34:0];
          state <= S_CCD;
        end

        S_CCD: begin
          cd    <= mul_p[34:0];
          state <= S_CCMP;
        end

        S_CCMP: begin
          hit   <= dot_sum > $signed({cd[34], cd});
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted item always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  // A result beat appears only when the sequencer finishes an item.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the finish state");

  // A blocked output register keeps the sequencer waiting.
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_valid && !result_out.ready) |=> state == S_DONE)
    else $error("result overwritten while stalled");

  // The direction stays within unit magnitude per component.
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    dir_x <= DIR_ONE && dir_x >= -DIR_ONE && dir_y <= DIR_ONE && dir_y >= -DIR_ONE)
    else $error("direction component beyond unit length");

endmodule

[tb/sv/pcpc_cone_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcpc_cone_checker
// Watches the item and result channels of the pen cone tracker, keeps its own
// copy of apex, direction and cone registers, predicts each result beat and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pcpc_cone_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  pcpc_item_if        item_in,
  pcpc_result_if      result_out,
  output int          fail_count,
  output int          pending
);
  import pcpc_pkg::*;

  typedef struct packed {
    logic inside_res;
    logic alive;
    logic active;
  } verdict_t;

  verdict_t verdict_q[$];

  // Tracker copy.
  logic signed [15:0] apex_x, apex_y;
  logic [31:0]        pos_stamp, dir_stamp;
  logic               pos_seen, dir_seen;
  logic signed [16:0] head_x, head_y;
  logic [15:0]        radius;
  logic signed [15:0] cos_half;

  assign pending = verdict_q.size();

  // Integer square root, floor.
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Half-life decay weight in Q15 for an age in milliseconds.
  function automatic longint decay_q15(input logic [31:0] age);
    longint unsigned whole, rest, frac, w, c;
    whole = age / 1000;
    rest  = age % 1000;
    frac  = (rest << 15) / 1000;
    w = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int k = 1; k <= 15; k++) begin
      c = root64(c << 30);
      if (frac[15-k]) w = (w * c) >> 30;
    end
    if (whole > 30) return 0;
    return longint'((w >> whole) >> 15);
  endfunction

  // One component of a unit vector, given the squared length.
  function automatic longint unit_part(input longint a, input longint unsigned len2);
    longint unsigned mag;
    mag = (a < 0) ? -a : a;
    mag = root64(((mag * mag) << 30) / len2);
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  task automatic to_unit(input longint a, input longint b,
                         output longint ua, output longint ub);
    longint unsigned len2;
    len2 = a * a + b * b;
    if (len2 == 0) begin
      ua = 0;
      ub = 0;
    end else begin
      ua = unit_part(a, len2);
      ub = unit_part(b, len2);
    end
  endtask

  function automatic logic pen_active(input logic [31:0] stamp);
    logic [31:0] age;
    age = stamp - pos_stamp;
    return pos_seen && (age < ACTIVE_MS);
  endfunction

  // Applies one item to the tracker copy and returns the expected result.
  task automatic predict_verdict(input logic [1:0] kind, input logic signed [15:0] px,
                                 input logic signed [15:0] py, input logic [31:0] stamp,
                                 output verdict_t v);
    longint w, ux, uy, sx, sy, nx, ny, dx, dy, d, dot;
    longint unsigned dist2;
    v = '0;
    if (kind == KIND_POS) begin
      apex_x    = px;
      apex_y    = py;
      pos_stamp = stamp;
      pos_seen  = 1'b1;
    end else if (kind == KIND_DIR) begin
      w = dir_seen ? decay_q15(stamp - dir_stamp) : 0;
      to_unit(longint'(px) - apex_x, longint'(py) - apex_y, ux, uy);
      sx = ((w * head_x) >>> 15) + ux;
      sy = ((w * head_y) >>> 15) + uy;
      to_unit(sx, sy, nx, ny);
      head_x    = nx;
      head_y    = ny;
      dir_stamp = stamp;
      dir_seen  = 1'b1;
    end else if (kind == KIND_CHECK && pen_active(stamp)) begin
      dx = longint'(px) - apex_x;
      dy = longint'(py) - apex_y;
      dist2 = dx * dx + dy * dy;
      if (dist2 <= longint'(radius) * longint'(radius)) begin
        d   = longint'(root64(dist2));
        dot = dx * head_x + dy * head_y;
        v.inside_res = (dot > longint'(cos_half) * d);
      end
    end
    v.alive  = pos_seen;
    v.active = pen_active(stamp);
  endtask

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      apex_x = '0; apex_y = '0; pos_stamp = '0; dir_stamp = '0;
      pos_seen = 1'b0; dir_seen = 1'b0; head_x = '0; head_y = '0;
      radius = '0; cos_half = '0;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RADIUS) radius = cfg_data;
        else cos_half = cfg_data;
      end
      // Compare the result beat first: it always belongs to an older item.
      if (result_out.valid && result_out.ready) begin
        if (verdict_q.size() == 0) begin
          $display("[%0t] result beat with no item outstanding", $time);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (result_out.inside_res !== want.inside_res)
            report_mismatch("inside_res", result_out.inside_res, want.inside_res);
          if (result_out.alive !== want.alive)
            report_mismatch("alive", result_out.alive, want.alive);
          if (result_out.active !== want.active)
            report_mismatch("active", result_out.active, want.active);
        end
      end
      if (item_in.valid && item_in.ready) begin
        predict_verdict(item_in.kind, item_in.x, item_in.y, item_in.now_ms, want);
        verdict_q.push_back(want);
      end
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the pen cone tracker bench: drives directed and random item beats
// under varying idle patterns and cone settings; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
  import pcpc_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 3000;
  localparam int SEG_ITEMS   = 165;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int          tx_idle_pct, rx_idle_pct;
  bit          hold_go, hold_done;
  int          hold_left;
  int          quiet_cycles;
  logic [31:0] clock_ms;
  logic signed [15:0] cur_x, cur_y;

  pcpc_item_if   item_bus ();
  pcpc_result_if res_bus ();

  pen_cone_palm_check uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_bus),
    .result_out (res_bus)
  );

  pcpc_cone_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_bus),
    .result_out (res_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] kind, input logic signed [15:0] px,
                           input logic signed [15:0] py, input logic [31:0] stamp);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    item_bus.valid  <= 1'b1;
    item_bus.kind   <= kind;
    item_bus.x      <= px;
    item_bus.y      <= py;
    item_bus.now_ms <= stamp;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_POS) begin
      cur_x = px;
      cur_y = py;
    end
  endtask

  // Writes both cone registers once every outstanding result has come back.
  task automatic set_cone(input logic [15:0] rad, input logic [15:0] cosv);
    item_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RADIUS;
    cfg_data  <= rad;
    @(negedge clk);
    cfg_index <= CFG_COS;
    cfg_data  <= cosv;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [15:0] near(input logic signed [15:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Mostly well-formed pen traffic around the current apex, some raw noise.
  task automatic random_beat();
    int pick;
    int span;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_beat(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), $urandom);
    end else begin
      if ($urandom_range(49) == 0) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 120);
      span = ($urandom_range(9) == 0) ? 32767 : $urandom_range(10, 3000);
      pick = $urandom_range(99);
      if (pick < 20)
        send_beat(KIND_POS, near(cur_x, 4000), near(cur_y, 4000), clock_ms);
      else if (pick < 50)
        send_beat(KIND_DIR, near(cur_x, span), near(cur_y, span), clock_ms);
      else
        send_beat(KIND_CHECK, near(cur_x, span), near(cur_y, span), clock_ms);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_RADIUS; cfg_data = '0;
    item_bus.valid = 1'b0; item_bus.kind = KIND_POS;
    item_bus.x = '0; item_bus.y = '0; item_bus.now_ms = '0;
    tx_idle_pct = 13; rx_idle_pct = 81;
    hold_go = 1'b0;
    clock_ms = 32'd1000;
    cur_x = '0; cur_y = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: cone of 45 degrees, radius 1000.
    set_cone(16'd1000, 16'd23170);
    send_beat(KIND_CHECK, 16'sd5, 16'sd5, 32'd100);          // nothing seen yet
    send_beat(KIND_UNUSED, 16'sd7, -16'sd7, 32'd200);        // unused kind
    send_beat(KIND_POS, 16'sd32767, 16'sd32767, 32'd900);
    send_beat(KIND_CHECK, -16'sd32768, -16'sd32768, 32'd910); // far outside radius
    send_beat(KIND_POS, 16'sd0, 16'sd0, 32'd1000);
    send_beat(KIND_DIR, 16'sd0, 16'sd0, 32'd1000);           // first update, on the apex
    send_beat(KIND_DIR, 16'sd10, 16'sd0, 32'd1000);          // full weight, zero history
    send_beat(KIND_DIR, -16'sd10, 16'sd0, 32'd1000);         // sum cancels to zero
    send_beat(KIND_DIR, 16'sd100, 16'sd0, 32'd1050);
    send_beat(KIND_CHECK, 16'sd50, 16'sd10, 32'd1060);
    send_beat(KIND_CHECK, -16'sd50, 16'sd0, 32'd1070);
    send_beat(KIND_CHECK, 16'sd0, 16'sd0, 32'd1080);          // point on the apex
    send_beat(KIND_CHECK, 16'sd50, 16'sd10, 32'd1300);        // just stale
    send_beat(KIND_DIR, 16'sd0, 16'sd100, 32'd41050);         // long gap, weight saturates
    send_beat(KIND_POS, 16'sd0, 16'sd0, 32'hFFFF_FF00);
    send_beat(KIND_DIR, 16'sd100, 16'sd100, 32'h0000_0020);   // time wraps
    send_beat(KIND_CHECK, 16'sd30, 16'sd30, 32'h0000_0040);
    send_beat(KIND_POS, -16'sd32768, 16'sd32767, 32'h0000_0050);
    send_beat(KIND_DIR, 16'sd32767, -16'sd32768, 32'h0000_0060);
    set_cone(16'd65535, 16'h8000);
    send_beat(KIND_CHECK, 16'sd32767, -16'sd32768, 32'h0000_0070);
    send_beat(KIND_CHECK, -16'sd32768, 16'sd32767, 32'h0000_0080);
    clock_ms = 32'h0000_0100;

    // Random part in four segments of idling and cone settings.
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          tx_idle_pct = 13; rx_idle_pct = 81;
          set_cone(16'($urandom_range(200, 4000)), 16'($urandom));
        end
        1: begin
          tx_idle_pct = 81; rx_idle_pct = 13;
          set_cone(16'd65535, 16'h8000);
        end
        2: begin
          tx_idle_pct = 0; rx_idle_pct = 0;
          set_cone(16'($urandom_range(200, 4000)), 16'($urandom));
          hold_go = 1'b1;
        end
        default: begin
          tx_idle_pct = 0; rx_idle_pct = 0;
          set_cone(16'd0, 16'h7FFF);
        end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) random_beat();
    end

    // Drain and settle.
    item_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/pcpc_pkg.sv
rtl/pcpc_ifs.sv
rtl/pen_cone_palm_check.sv
tb/sv/pcpc_cone_checker.sv
tb/sv/tb.sv
